// ===== sv/ckblit_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter package
// Shared widths, the key color, register indexes and the configuration type.
// ----------------------------------------------------------------------------
`default_nettype none

package ckblit_pkg;

  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned ADDR_W     = 19;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned SIDE_CFG_W = 11;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [COLOR_W-1:0] KEY_COLOR = 32'hFF00FF00;

  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_MIRROR        = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [SIDE_CFG_W-1:0]     sprite_width;
    logic [SIDE_CFG_W-1:0]     sprite_height;
    logic                      mirror;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/ckblit_regs.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter configuration registers
// APB-style register file holding destination, sprite size and mirror mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ckblit_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ckblit_pkg::PADDR_W-1:0]  paddr,
  input  logic [ckblit_pkg::PDATA_W-1:0]  pwdata,
  output logic [ckblit_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  output ckblit_pkg::cfg_t                cfg_o
);
  import ckblit_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_DEST_X:        cfg_d.dest_x        = $signed(pwdata[COORD_W-1:0]);
        REG_DEST_Y:        cfg_d.dest_y        = $signed(pwdata[COORD_W-1:0]);
        REG_SPRITE_WIDTH:  cfg_d.sprite_width  = pwdata[SIDE_CFG_W-1:0];
        REG_SPRITE_HEIGHT: cfg_d.sprite_height = pwdata[SIDE_CFG_W-1:0];
        REG_MIRROR:        cfg_d.mirror        = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEST_X:        prdata = {{(PDATA_W-COORD_W){1'b0}}, cfg_q.dest_x};
      REG_DEST_Y:        prdata = {{(PDATA_W-COORD_W){1'b0}}, cfg_q.dest_y};
      REG_SPRITE_WIDTH:  prdata = {{(PDATA_W-SIDE_CFG_W){1'b0}}, cfg_q.sprite_width};
      REG_SPRITE_HEIGHT: prdata = {{(PDATA_W-SIDE_CFG_W){1'b0}}, cfg_q.sprite_height};
      REG_MIRROR:        prdata = {{(PDATA_W-1){1'b0}}, cfg_q.mirror};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x        <= '0;
      cfg_q.dest_y        <= '0;
      cfg_q.sprite_width  <= SIDE_CFG_W'(1);
      cfg_q.sprite_height <= SIDE_CFG_W'(1);
      cfg_q.mirror        <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ckblit_walk.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter source walker
// Row and column counters over the sprite, frame position and clip/key test.
// ----------------------------------------------------------------------------
`default_nettype none

module ckblit_walk #(
  parameter int unsigned FRAME_WIDTH     = 640,
  parameter int unsigned FRAME_HEIGHT    = 480,
  parameter int unsigned MAX_SPRITE_SIDE = 1024,
  localparam int unsigned XW = $clog2(FRAME_WIDTH),
  localparam int unsigned YW = $clog2(FRAME_HEIGHT)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ckblit_pkg::cfg_t                cfg_i,
  input  logic                            advance_i,
  input  logic [ckblit_pkg::COLOR_W-1:0]  src_pixel_i,
  output logic                            hit_o,
  output logic [XW-1:0]                   fx_o,
  output logic [YW-1:0]                   fy_o
);
  import ckblit_pkg::*;

  localparam int unsigned SIDE_W = $clog2(MAX_SPRITE_SIDE + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_SPRITE_SIDE);
  localparam int unsigned CMP_W  = (SIDE_W > SIDE_CFG_W) ? SIDE_W : SIDE_CFG_W;
  localparam int unsigned POS_W  = ((SIDE_W > COORD_W) ? SIDE_W : COORD_W) + 2;

  logic [CNT_W-1:0]        col_q, col_d, row_q, row_d;
  logic [CMP_W-1:0]        w_raw, h_raw;
  logic [SIDE_W-1:0]       w_eff, h_eff, col_inc, row_inc;
  logic                    col_wrap, row_wrap;
  logic signed [POS_W-1:0] w_s, c_s, r_s, dx_s, dy_s, col_pos, fx, fy;
  logic                    in_x, in_y;

  // Sizes of zero count as one, sizes above the maximum are clamped.
  assign w_raw = CMP_W'(cfg_i.sprite_width);
  assign h_raw = CMP_W'(cfg_i.sprite_height);
  assign w_eff = (w_raw == '0) ? SIDE_W'(1) :
                 (w_raw > CMP_W'(MAX_SPRITE_SIDE)) ? SIDE_W'(MAX_SPRITE_SIDE) :
                 SIDE_W'(w_raw);
  assign h_eff = (h_raw == '0) ? SIDE_W'(1) :
                 (h_raw > CMP_W'(MAX_SPRITE_SIDE)) ? SIDE_W'(MAX_SPRITE_SIDE) :
                 SIDE_W'(h_raw);

  assign col_inc  = SIDE_W'(col_q) + SIDE_W'(1);
  assign row_inc  = SIDE_W'(row_q) + SIDE_W'(1);
  assign col_wrap = (col_inc >= w_eff);
  assign row_wrap = (row_inc >= h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : CNT_W'(row_inc);
      end else begin
        col_d = CNT_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // A column left over from a larger size goes negative when mirrored.
  assign w_s     = signed'(POS_W'(w_eff));
  assign c_s     = signed'(POS_W'(col_q));
  assign r_s     = signed'(POS_W'(row_q));
  assign dx_s    = POS_W'(cfg_i.dest_x);
  assign dy_s    = POS_W'(cfg_i.dest_y);
  assign col_pos = cfg_i.mirror ? (w_s - c_s - POS_W'(1)) : c_s;
  assign fx      = dx_s + col_pos;
  assign fy      = dy_s + r_s;

  assign in_x  = !fx[POS_W-1] && (fx < signed'(POS_W'(FRAME_WIDTH)));
  assign in_y  = !fy[POS_W-1] && (fy < signed'(POS_W'(FRAME_HEIGHT)));
  assign hit_o = (src_pixel_i != KEY_COLOR) && in_x && in_y;
  assign fx_o  = fx[XW-1:0];
  assign fy_o  = fy[YW-1:0];

endmodule

`default_nettype wire

// ===== sv/color_keyed_sprite_blit_core.sv =====
// ----------------------------------------------------------------------------
// Color-keyed sprite blitter core
// Maps a row-major pixel stream onto frame-buffer writes with key and clipping.
// A pixel that yields a write is registered in the position stage, then in the
// address multiply stage, before it shows on the output.
// Throughput: 1 pixel per cycle; a stall on the output holds the pipeline.
// Reset: counters, valid flags and config registers reset; data registers do not.
// ----------------------------------------------------------------------------
`default_nettype none

module color_keyed_sprite_blit_core #(
  parameter int unsigned FRAME_WIDTH     = 640,
  parameter int unsigned FRAME_HEIGHT    = 480,
  parameter int unsigned MAX_SPRITE_SIDE = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ckblit_pkg::PADDR_W-1:0]  paddr,
  input  logic [ckblit_pkg::PDATA_W-1:0]  pwdata,
  output logic [ckblit_pkg::PDATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ckblit_pkg::COLOR_W-1:0]  src_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ckblit_pkg::ADDR_W-1:0]   fb_address_o,
  output logic [ckblit_pkg::COLOR_W-1:0]  pixel_color_o
);
  import ckblit_pkg::*;

  localparam int unsigned XW     = $clog2(FRAME_WIDTH);
  localparam int unsigned YW     = $clog2(FRAME_HEIGHT);
  localparam int unsigned PROD_W = XW + YW;

  cfg_t                cfg;
  logic                accept, hit, out_go, s1_go;
  logic [XW-1:0]       fx;
  logic [YW-1:0]       fy;
  logic                s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic [XW-1:0]       s1_fx_q;
  logic [YW-1:0]       s1_fy_q;
  logic [COLOR_W-1:0]  s1_color_q, out_color_q;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [PROD_W-1:0]   prod;

  ckblit_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ckblit_walk #(
    .FRAME_WIDTH     (FRAME_WIDTH),
    .FRAME_HEIGHT    (FRAME_HEIGHT),
    .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (accept),
    .src_pixel_i (src_pixel_i),
    .hit_o       (hit),
    .fx_o        (fx),
    .fy_o        (fy)
  );

  // Each stage moves when the one after it is empty or draining. Dropped
  // pixels never occupy a stage, they only advance the counters.
  assign out_go     = !out_valid_q || out_ready_i;
  assign s1_go      = !s1_valid_q || out_go;
  assign in_ready_o = s1_go;
  assign accept     = in_valid_i && s1_go;

  assign s1_valid_d  = s1_go ? (accept && hit) : s1_valid_q;
  assign out_valid_d = out_go ? s1_valid_q : out_valid_q;

  assign prod       = PROD_W'(s1_fy_q) * PROD_W'(FRAME_WIDTH) + PROD_W'(s1_fx_q);
  assign out_addr_d = ADDR_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      s1_fx_q    <= fx;
      s1_fy_q    <= fy;
      s1_color_q <= src_pixel_i;
    end
    if (out_go && s1_valid_q) begin
      out_addr_q  <= out_addr_d;
      out_color_q <= s1_color_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fb_address_o  = out_addr_q;
  assign pixel_color_o = out_color_q;

endmodule

`default_nettype wire

// ===== sv/ckblit_checker.sv =====
// ----------------------------------------------------------------------------
// Sprite blitter port checker
// Watches the stream ports of the core for stalls, keying and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module ckblit_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [ckblit_pkg::ADDR_W-1:0]   fb_address_o,
  input logic [ckblit_pkg::COLOR_W-1:0]  pixel_color_o
);
  import ckblit_pkg::*;

  // A pending result must hold still until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fb_address_o) &&
    $stable(pixel_color_o))
    else $error("output item changed while stalled");

  // The key color is never written.
  a_no_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixel_color_o != KEY_COLOR)
    else $error("key color pixel was written");

  // The input only stalls under output backpressure.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // From an empty pipe, a write appears once its item passes stage 1 and the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output item without a matching input item");

endmodule

bind color_keyed_sprite_blit_core ckblit_checker u_ckblit_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite blitter testbench
// Streams sprite pixels through the blitter and checks each frame-buffer write
// against an in-bench model of the placement, key and clipping rules. A short
// table of directed rows comes first, then random register settings and pixel
// bursts with random stalls on both sides and one long output stall.
// ----------------------------------------------------------------------------

module tb;

  import ckblit_pkg::*;

  localparam int FRAME_W         = 640;
  localparam int FRAME_H         = 480;
  localparam int MAX_SIDE        = 1024;
  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int DRAIN_CYCLES    = 4;
  localparam int RANDOM_ITEMS    = 1930;
  localparam int PRESSURE_AT     = 60;
  localparam int PRESSURE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int MAX_REPORTS     = 100;
  localparam int NUM_REGS        = int'(REG_MIRROR) + 1;
  localparam int REG_SLOTS       = 1 << (PADDR_W - 2);

  typedef enum logic [1:0] {CHK_PREDICT, CHK_DROP, CHK_WRITE} row_check_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_TRICKLE, RX_MOSTLY} rx_mode_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  fb_address;
    logic [COLOR_W-1:0] pixel_color;
  } fb_write_t;

  typedef struct {
    bit                is_cfg;
    int unsigned       slot;
    logic [31:0]       value;
    row_check_e        check;
    logic [ADDR_W-1:0] addr;
  } blit_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [COLOR_W-1:0] src_pixel_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [ADDR_W-1:0]  fb_address_o;
  logic [COLOR_W-1:0] pixel_color_o;

  // Travels with each pixel so the checker knows whether a row carries a
  // hand-written expectation.
  row_check_e         row_check   = CHK_PREDICT;
  logic [ADDR_W-1:0]  row_addr    = '0;

  cfg_t blit_cfg = '{dest_x: '0, dest_y: '0, sprite_width: 11'd1, sprite_height: 11'd1,
                     mirror: 1'b0};
  logic [9:0] col_pos = '0;
  logic [9:0] row_pos = '0;

  fb_write_t pending_writes[$];
  int        pixels_in    = 0;
  int        writes_out   = 0;
  int        fail_count   = 0;
  int        quiet_cycles = 0;

  color_keyed_sprite_blit_core #(
    .FRAME_WIDTH    (FRAME_W),
    .FRAME_HEIGHT   (FRAME_H),
    .MAX_SPRITE_SIDE(MAX_SIDE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .src_pixel_i  (src_pixel_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .fb_address_o (fb_address_o),
    .pixel_color_o(pixel_color_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int eff_side(input logic [SIDE_CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  // Places one pixel and advances the source counters.
  function automatic bit blit_step(input logic [COLOR_W-1:0] pix,
                                   output logic [ADDR_W-1:0] addr);
    int w, h, col, fx, fy;
    bit lands;
    w = eff_side(blit_cfg.sprite_width);
    h = eff_side(blit_cfg.sprite_height);
    col = blit_cfg.mirror ? w - 1 - int'(col_pos) : int'(col_pos);
    fx = int'($signed(blit_cfg.dest_x)) + col;
    fy = int'($signed(blit_cfg.dest_y)) + int'(row_pos);
    lands = (pix != KEY_COLOR) && fx >= 0 && fx < FRAME_W && fy >= 0 && fy < FRAME_H;
    addr = ADDR_W'(fy * FRAME_W + fx);
    // A counter left beyond a shrunken size simply wraps at its next advance.
    if (int'(col_pos) + 1 >= w) begin
      col_pos = '0;
      row_pos = (int'(row_pos) + 1 >= h) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return lands;
  endfunction

  function automatic bit count_fail();
    fail_count++;
    return fail_count <= MAX_REPORTS;
  endfunction

  function automatic blit_row_t cfg_row(input int unsigned slot, input logic [31:0] value);
    blit_row_t r;
    r = '{is_cfg: 1'b1, slot: slot, value: value, check: CHK_PREDICT, addr: '0};
    return r;
  endfunction

  function automatic blit_row_t px_row(input logic [31:0] pix, input row_check_e chk,
                                       input logic [ADDR_W-1:0] addr);
    blit_row_t r;
    r = '{is_cfg: 1'b0, slot: 0, value: pix, check: chk, addr: addr};
    return r;
  endfunction

  function automatic int pick_coord(input int span);
    case ($urandom_range(0, 11))
      0:       return -2048;
      1:       return 2047;
      2:       return -1;
      3:       return span - 1;
      4:       return span;
      5:       return int'($urandom_range(0, 4095)) - 2048;
      default: return int'($urandom_range(0, span + 40)) - 40;
    endcase
  endfunction

  function automatic int pick_side();
    case ($urandom_range(0, 11))
      0:       return 0;
      1:       return int'($urandom_range(MAX_SIDE, (1 << SIDE_CFG_W) - 1));
      2:       return int'($urandom_range(1, MAX_SIDE - 1));
      default: return int'($urandom_range(1, 24));
    endcase
  endfunction

  task automatic write_reg(input int unsigned slot, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(slot * 4);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sometimes sets junk above the register width; the block must drop it.
  task automatic put_reg(input reg_idx_e idx, input int value, input int unsigned width);
    logic [31:0] data;
    data = 32'(value) & ((32'd1 << width) - 32'd1);
    if ($urandom_range(0, 3) == 0) data |= $urandom() << width;
    write_reg(int'(idx), data);
  endtask

  task automatic drive_pixel(input logic [COLOR_W-1:0] pix, input row_check_e chk,
                             input logic [ADDR_W-1:0] addr);
    in_valid_i  <= 1'b1;
    src_pixel_i <= pix;
    row_check   <= chk;
    row_addr    <= addr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Pixels that are keyed or clipped leave no trace in the queue, so an extra
  // drain wait lets them clear the pipeline before registers change.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : scoreboard
    logic [ADDR_W-1:0] addr;
    bit                lands;
    bit                busy;
    fb_write_t         want;
    busy = 1'b0;
    if (rst_ni) begin
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        case (paddr[PADDR_W-1:2])
          REG_DEST_X:        blit_cfg.dest_x        = pwdata[COORD_W-1:0];
          REG_DEST_Y:        blit_cfg.dest_y        = pwdata[COORD_W-1:0];
          REG_SPRITE_WIDTH:  blit_cfg.sprite_width  = pwdata[SIDE_CFG_W-1:0];
          REG_SPRITE_HEIGHT: blit_cfg.sprite_height = pwdata[SIDE_CFG_W-1:0];
          REG_MIRROR:        blit_cfg.mirror        = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        busy = 1'b1;
        lands = blit_step(src_pixel_i, addr);
        if (row_check == CHK_WRITE) begin
          lands = 1'b1;
          addr  = row_addr;
        end else if (row_check == CHK_DROP) begin
          lands = 1'b0;
        end
        if (lands) pending_writes.push_back('{fb_address: addr, pixel_color: src_pixel_i});
        pixels_in++;
      end
      if (out_valid_o && out_ready_i) begin
        busy = 1'b1;
        writes_out++;
        if (pending_writes.size() == 0) begin
          if (count_fail())
            $display("%0t: unexpected write, expected none, got address %0d color %h",
                     $time, fb_address_o, pixel_color_o);
        end else begin
          want = pending_writes.pop_front();
          if (fb_address_o !== want.fb_address && count_fail())
            $display("%0t: fb_address expected %0d, got %0d",
                     $time, want.fb_address, fb_address_o);
          if (pixel_color_o !== want.pixel_color && count_fail())
            $display("%0t: pixel_color expected %h, got %h",
                     $time, want.pixel_color, pixel_color_o);
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : receiver
    int       seg;
    rx_mode_e mode;
    bit       squeezed;
    squeezed = 1'b0;
    @(posedge rst_ni);
    forever begin
      seg  = $urandom_range(8, 64);
      mode = rx_mode_e'($urandom_range(0, 3));
      repeat (seg) begin
        case (mode)
          RX_OPEN:    out_ready_i <= 1'b1;
          RX_COIN:    out_ready_i <= 1'($urandom_range(0, 1));
          RX_TRICKLE: out_ready_i <= ($urandom_range(0, 7) == 0);
          default:    out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
      // One long hold-off while pixels keep coming, so the input side backs up.
      if (!squeezed && pixels_in >= PRESSURE_AT) begin
        out_ready_i <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk_i);
        squeezed = 1'b1;
      end
    end
  end

  initial begin : stimulus
    blit_row_t          dir_rows[$];
    bit                 streaming;
    bit                 gappy;
    int                 phase, len, sent, burst_left, gap;
    logic [COLOR_W-1:0] pix;

    dir_rows.push_back(px_row(32'h0000_0000, CHK_WRITE, '0));
    dir_rows.push_back(px_row(32'hFFFF_FFFF, CHK_WRITE, '0));
    dir_rows.push_back(px_row(KEY_COLOR, CHK_DROP, '0));
    dir_rows.push_back(px_row(KEY_COLOR ^ 32'h0000_0001, CHK_WRITE, '0));
    dir_rows.push_back(px_row(KEY_COLOR ^ 32'h8000_0000, CHK_WRITE, '0));
    // A 2x2 sprite at the bottom-right corner: only its first pixel lands.
    dir_rows.push_back(cfg_row(REG_DEST_X, FRAME_W - 1));
    dir_rows.push_back(cfg_row(REG_DEST_Y, FRAME_H - 1));
    dir_rows.push_back(cfg_row(REG_SPRITE_WIDTH, 2));
    dir_rows.push_back(cfg_row(REG_SPRITE_HEIGHT, 2));
    dir_rows.push_back(px_row(32'h1234_5678, CHK_WRITE, ADDR_W'(FRAME_W * FRAME_H - 1)));
    dir_rows.push_back(px_row(32'h0000_0001, CHK_DROP, '0));
    dir_rows.push_back(px_row(32'h8000_0000, CHK_DROP, '0));
    dir_rows.push_back(px_row(32'h5A5A_A5A5, CHK_DROP, '0));
    dir_rows.push_back(cfg_row(REG_DEST_X, 32'h0000_0800));
    dir_rows.push_back(cfg_row(REG_DEST_Y, 32'h0000_07FF));
    dir_rows.push_back(px_row(32'hC0FF_EE00, CHK_DROP, '0));
    dir_rows.push_back(px_row(32'h0F0F_0F0F, CHK_DROP, '0));
    // Clamped sizes and mirroring, entered with the counters mid-sprite.
    dir_rows.push_back(cfg_row(REG_MIRROR, 1));
    dir_rows.push_back(cfg_row(REG_DEST_X, 0));
    dir_rows.push_back(cfg_row(REG_DEST_Y, 0));
    dir_rows.push_back(cfg_row(REG_SPRITE_WIDTH, 0));
    dir_rows.push_back(cfg_row(REG_SPRITE_HEIGHT, 32'h0000_07FF));
    dir_rows.push_back(px_row(32'h0000_00AA, CHK_PREDICT, '0));
    dir_rows.push_back(px_row(32'h0000_00BB, CHK_PREDICT, '0));
    dir_rows.push_back(cfg_row(REG_DEST_X, 32'h0000_0FFF));
    dir_rows.push_back(cfg_row(REG_SPRITE_WIDTH, 3));
    dir_rows.push_back(cfg_row(REG_SPRITE_HEIGHT, 1));
    dir_rows.push_back(px_row(32'h1111_1111, CHK_PREDICT, '0));
    dir_rows.push_back(px_row(32'h2222_2222, CHK_PREDICT, '0));
    dir_rows.push_back(px_row(32'h3333_3333, CHK_PREDICT, '0));
    for (int s = NUM_REGS; s < REG_SLOTS; s++) dir_rows.push_back(cfg_row(s, 32'hFFFF_FFFF));
    dir_rows.push_back(px_row(32'h4444_4444, CHK_PREDICT, '0));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    streaming = 1'b0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (streaming) wait_idle();
        streaming = 1'b0;
        write_reg(dir_rows[i].slot, dir_rows[i].value);
      end else begin
        drive_pixel(dir_rows[i].value, dir_rows[i].check, dir_rows[i].addr);
        streaming = 1'b1;
      end
    end

    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 0) begin
        // Fully on-screen and gap-free, so the long output stall backs up the input.
        put_reg(REG_DEST_X, 0, COORD_W);
        put_reg(REG_DEST_Y, 0, COORD_W);
        put_reg(REG_SPRITE_WIDTH, 16, SIDE_CFG_W);
        put_reg(REG_SPRITE_HEIGHT, 8, SIDE_CFG_W);
        put_reg(REG_MIRROR, 0, 1);
        len   = 300;
        gappy = 1'b0;
      end else begin
        if ($urandom_range(0, 3) != 0) put_reg(REG_DEST_X, pick_coord(FRAME_W), COORD_W);
        if ($urandom_range(0, 3) != 0) put_reg(REG_DEST_Y, pick_coord(FRAME_H), COORD_W);
        if ($urandom_range(0, 3) != 0) put_reg(REG_SPRITE_WIDTH, pick_side(), SIDE_CFG_W);
        if ($urandom_range(0, 3) != 0) put_reg(REG_SPRITE_HEIGHT, pick_side(), SIDE_CFG_W);
        if ($urandom_range(0, 3) != 0) put_reg(REG_MIRROR, $urandom_range(0, 1), 1);
        len   = $urandom_range(16, 160);
        gappy = ($urandom_range(0, 3) != 0);
      end
      burst_left = 0;
      for (int n = 0; n < len; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = gappy ? $urandom_range(0, 12) : 0;
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        case ($urandom_range(0, 15))
          0, 1:    pix = KEY_COLOR;
          2:       pix = KEY_COLOR ^ (32'd1 << $urandom_range(0, 31));
          default: pix = $urandom();
        endcase
        drive_pixel(pix, CHK_PREDICT, '0);
        burst_left--;
      end
      sent += len;
      phase++;
    end
    wait_idle();

    $display("Checked %0d frame writes from %0d pixels over %0d random register settings.",
             writes_out, pixels_in, phase);
    $display("Included key colors, clipping on all frame edges, mirroring, clamped sizes %s",
             "and a long output stall.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== color_keyed_sprite_blit_core.f =====
sv/ckblit_pkg.sv
sv/ckblit_regs.sv
sv/ckblit_walk.sv
sv/color_keyed_sprite_blit_core.sv
sv/ckblit_checker.sv
tb/tb.sv
